// ----- rtl/core/skrs_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package skrs_pkg;

  localparam int unsigned RSSI_W    = 8;
  localparam int unsigned FIX_W     = 16;
  localparam int unsigned CFG_IDX_W = 2;

  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  localparam cfg_idx_t REG_PROCESS_NOISE     = 2'd0;
  localparam cfg_idx_t REG_MEASUREMENT_NOISE = 2'd1;

endpackage

`default_nettype wire

// ----- rtl/core/scalar_kalman_rssi_smoother.sv -----
`timescale 1ns / 1ps
`default_nettype none

// One-dimensional Kalman smoother for RSSI samples. Each input transfer carries a raw
// sample in whole dBm and produces one output transfer with the filtered estimate in
// signed fixed point (FRAC_BITS fraction bits). The first sample after reset or after a
// write to a noise register seeds the estimate and goes from ST_PREP straight to ST_DONE.
// Every later sample passes through ST_PREP, ST_DIV and ST_MUL: the gain comes
// from a restoring divider that yields one quotient bit per cycle, and both products
// (estimate step and variance scaling) run through shift-add multipliers that consume
// one gain bit per cycle. One sample is in flight at a time; a new sample is taken while
// the previous result still waits on the output. Registers are written only while idle;
// a write of zero to a noise register selects its default (q = 0.5, r = 4.0).
module scalar_kalman_rssi_smoother #(
  parameter int unsigned FRAC_BITS = 8,
  parameter int unsigned GAIN_BITS = 16
) (
  input  wire                        clk_i,
  input  wire                        rst_ni,
  input  wire                        s_axis_tvalid,
  output logic                       s_axis_tready,
  input  wire  [skrs_pkg::RSSI_W-1:0] s_axis_tdata,   // [7:0] rssi_sample
  output logic                       m_axis_tvalid,
  input  wire                        m_axis_tready,
  output logic [skrs_pkg::FIX_W-1:0] m_axis_tdata,    // [15:0] smoothed_rssi
  input  wire                        cfg_valid_i,
  output logic                       cfg_ready_o,
  input  wire  [skrs_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  wire  [skrs_pkg::FIX_W-1:0] cfg_data_i
);

  import skrs_pkg::*;

  localparam int unsigned SW = RSSI_W + FRAC_BITS;
  localparam int unsigned CW = $clog2(GAIN_BITS);
  localparam logic [FIX_W-1:0] DEF_Q   = FIX_W'(32'd1 << (FRAC_BITS - 1));
  localparam logic [FIX_W-1:0] DEF_R   = FIX_W'(32'd4 << FRAC_BITS);
  localparam logic [FIX_W-1:0] ONE_FIX = FIX_W'(32'd1 << FRAC_BITS);
  localparam logic [CW-1:0]    CNT_LAST = CW'(GAIN_BITS - 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_PREP,
    ST_DIV,
    ST_MUL,
    ST_DONE
  } state_e;

  state_e                 state_q;
  logic [FIX_W-1:0]       q_noise_q, r_noise_q;
  logic signed [FIX_W-1:0] est_q, samp_q;
  logic [FIX_W-1:0]       var_q, v_q, mag_q;
  logic                   primed_q, neg_q, seen_q, gzero_q;
  logic [FIX_W:0]         den_q, rem_q;
  logic [GAIN_BITS-1:0]   gain_q;
  logic [CW-1:0]          cnt_q;
  logic [FIX_W:0]         acc_e_q, acc_v_q;
  logic                   m_valid_q;
  logic [FIX_W-1:0]       m_data_q;

  logic signed [SW-1:0]   samp_wide;
  logic signed [FIX_W-1:0] samp_fix;
  logic [FIX_W-1:0]       q_eff, r_eff, v_new;
  logic [FIX_W:0]         v_sum;
  logic signed [FIX_W:0]  diff;
  logic [FIX_W+1:0]       rem2;
  logic                   rem_ge;
  logic [FIX_W:0]         rem_d;
  logic [GAIN_BITS-1:0]   gain_d;
  logic                   mul_last, gbit, gbit_n;
  logic [FIX_W+1:0]       sum_e, sum_v;
  logic [FIX_W:0]         acc_e_d, acc_v_d;
  logic signed [FIX_W+1:0] est_ext;
  logic signed [FIX_W-1:0] est_new;
  logic                   out_free;

  assign samp_wide = {{FRAC_BITS{s_axis_tdata[RSSI_W-1]}}, s_axis_tdata} << FRAC_BITS;

  always_comb begin
    if (samp_wide > 32767) begin
      samp_fix = 16'sh7FFF;
    end else if (samp_wide < -32768) begin
      samp_fix = 16'sh8000;
    end else begin
      samp_fix = FIX_W'(samp_wide);
    end
  end

  assign q_eff = (q_noise_q == '0) ? DEF_Q : q_noise_q;
  assign r_eff = (r_noise_q == '0) ? DEF_R : r_noise_q;
  assign v_sum = {1'b0, var_q} + {1'b0, q_eff};
  assign v_new = v_sum[FIX_W] ? '1 : v_sum[FIX_W-1:0];
  assign diff  = {samp_q[FIX_W-1], samp_q} - {est_q[FIX_W-1], est_q};

  assign rem2   = {rem_q, 1'b0};
  assign rem_ge = rem2 >= {1'b0, den_q};
  assign rem_d  = rem_ge ? (FIX_W+1)'(rem2 - {1'b0, den_q}) : rem2[FIX_W:0];
  assign gain_d = {gain_q[GAIN_BITS-2:0], rem_ge};

  // LSB-first multipliers; the variance path negates the gain on the fly
  assign mul_last = (cnt_q == CNT_LAST);
  assign gbit     = gain_q[0];
  assign gbit_n   = seen_q ? ~gbit : gbit;
  assign sum_e    = {1'b0, acc_e_q} + (gbit ? {2'b00, mag_q} : '0)
                    + {{(FIX_W+1){1'b0}}, mul_last};
  assign sum_v    = {1'b0, acc_v_q} + (gbit_n ? {2'b00, v_q} : '0)
                    + {{(FIX_W+1){1'b0}}, mul_last};
  assign acc_e_d  = sum_e[FIX_W+1:1];
  assign acc_v_d  = sum_v[FIX_W+1:1];

  always_comb begin
    if (neg_q) begin
      est_ext = {{2{est_q[FIX_W-1]}}, est_q} - {1'b0, acc_e_d};
    end else begin
      est_ext = {{2{est_q[FIX_W-1]}}, est_q} + {1'b0, acc_e_d};
    end
    if (est_ext > 32767) begin
      est_new = 16'sh7FFF;
    end else if (est_ext < -32768) begin
      est_new = 16'sh8000;
    end else begin
      est_new = est_ext[FIX_W-1:0];
    end
  end

  assign out_free      = !m_valid_q || m_axis_tready;
  assign s_axis_tready = (state_q == ST_IDLE) && !cfg_valid_i;
  assign cfg_ready_o   = (state_q == ST_IDLE);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_IDLE;
      q_noise_q <= DEF_Q;
      r_noise_q <= DEF_R;
      est_q     <= '0;
      var_q     <= ONE_FIX;
      primed_q  <= 1'b0;
      samp_q    <= '0;
      v_q       <= '0;
      mag_q     <= '0;
      neg_q     <= 1'b0;
      den_q     <= '0;
      rem_q     <= '0;
      gain_q    <= '0;
      cnt_q     <= '0;
      acc_e_q   <= '0;
      acc_v_q   <= '0;
      seen_q    <= 1'b0;
      gzero_q   <= 1'b0;
      m_valid_q <= 1'b0;
      m_data_q  <= '0;
    end else begin
      if (m_valid_q && m_axis_tready && (state_q != ST_DONE)) begin
        m_valid_q <= 1'b0;
      end
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_valid_i) begin
            unique case (cfg_index_i)
              REG_PROCESS_NOISE: begin
                q_noise_q <= cfg_data_i;
                est_q     <= '0;
                var_q     <= ONE_FIX;
                primed_q  <= 1'b0;
              end
              REG_MEASUREMENT_NOISE: begin
                r_noise_q <= cfg_data_i;
                est_q     <= '0;
                var_q     <= ONE_FIX;
                primed_q  <= 1'b0;
              end
              default: begin
              end
            endcase
          end else if (s_axis_tvalid) begin
            samp_q  <= samp_fix;
            state_q <= ST_PREP;
          end
        end
        ST_PREP: begin
          if (!primed_q) begin
            est_q    <= samp_q;
            var_q    <= r_eff;
            primed_q <= 1'b1;
            state_q  <= ST_DONE;
          end else begin
            v_q     <= v_new;
            den_q   <= {1'b0, v_new} + {1'b0, r_eff};
            rem_q   <= {1'b0, v_new};
            neg_q   <= diff[FIX_W];
            mag_q   <= diff[FIX_W] ? FIX_W'(-diff) : diff[FIX_W-1:0];
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end
        end
        ST_DIV: begin
          rem_q  <= rem_d;
          gain_q <= gain_d;
          if (cnt_q == CNT_LAST) begin
            gzero_q <= (gain_d == '0);
            acc_e_q <= '0;
            acc_v_q <= '0;
            seen_q  <= 1'b0;
            cnt_q   <= '0;
            state_q <= ST_MUL;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_MUL: begin
          acc_e_q <= acc_e_d;
          acc_v_q <= acc_v_d;
          seen_q  <= seen_q | gbit;
          gain_q  <= gain_q >> 1;
          cnt_q   <= cnt_q + 1'b1;
          if (mul_last) begin
            est_q   <= est_new;
            var_q   <= gzero_q ? v_q : acc_v_d[FIX_W-1:0];
            state_q <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_free) begin
            m_valid_q <= 1'b1;
            m_data_q  <= est_q;
            state_q   <= ST_IDLE;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE && s_axis_tvalid && !cfg_valid_i) |=> (state_q == ST_PREP))
    else $error("accepted sample did not start processing");

  a_rem_below_den: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_DIV) |-> (rem_q < den_q))
    else $error("divider remainder out of range");

  a_var_shrinks: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_MUL && mul_last) |=> (var_q <= v_q))
    else $error("updated variance exceeds predicted variance");

  a_out_from_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_valid_q) |-> ($past(state_q) == ST_DONE))
    else $error("output raised outside the done state");

endmodule

`default_nettype wire

// ----- dv/tb_scalar_kalman_rssi_smoother.sv -----
`timescale 1ns / 1ps

module tb_scalar_kalman_rssi_smoother;
  import skrs_pkg::*;

  localparam int unsigned FRAC_BITS     = 8;
  localparam int unsigned GAIN_BITS     = 16;
  localparam int unsigned SETTLE_CYCLES = 3 + 2 * GAIN_BITS + 8;
  localparam int unsigned HOLD_CYCLES   = 400;
  localparam int unsigned SAMPLE_TARGET = 1300;

  localparam logic [FIX_W-1:0] Q_DEFAULT = 16'h0080;
  localparam logic [FIX_W-1:0] R_DEFAULT = 16'h0400;
  localparam logic [FIX_W-1:0] VAR_RESET = 16'h0100;

  localparam cfg_idx_t REG_SPARE_A = 2'd2;
  localparam cfg_idx_t REG_SPARE_B = 2'd3;

  typedef enum logic {ROW_WRITE, ROW_SAMPLE} row_kind_e;

  typedef struct packed {
    row_kind_e               kind;
    cfg_idx_t                idx;
    logic [FIX_W-1:0]        val;
    logic signed [RSSI_W-1:0] raw;
    logic                    typed;
    logic [FIX_W-1:0]        want;
  } stim_row_t;

  localparam int unsigned N_DIRECTED = 31;

  localparam stim_row_t DIRECTED_ROWS [N_DIRECTED] = '{
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd128, 1'b1, 16'h8000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd128, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd1,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd1,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     16'h0000,  8'sd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 16'h0000,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b1, 16'h7F00},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd128, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd60,  1'b0, 16'h0000},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     16'hFFFF,  8'sd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 16'h0001,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd1,   1'b1, 16'hFF00},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd128, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     16'h0001,  8'sd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 16'hFFFF,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd0,   1'b1, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd127, 1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd128, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_SPARE_A,           16'hFFFF,  8'sd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_SPARE_B,           16'h5555,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd100, 1'b0, 16'h0000},
    '{ROW_WRITE,  REG_PROCESS_NOISE,     16'h0080,  8'sd0,   1'b0, 16'h0000},
    '{ROW_WRITE,  REG_MEASUREMENT_NOISE, 16'h0400,  8'sd0,   1'b0, 16'h0000},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000,  8'sd5,   1'b1, 16'h0500},
    '{ROW_SAMPLE, REG_PROCESS_NOISE,     16'h0000, -8'sd70,  1'b0, 16'h0000}
  };

  logic                     clk_i         = 1'b0;
  logic                     rst_ni        = 1'b0;
  logic                     s_axis_tvalid = 1'b0;
  logic                     s_axis_tready;
  logic [RSSI_W-1:0]        s_axis_tdata  = '0;
  logic                     m_axis_tvalid;
  logic                     m_axis_tready = 1'b0;
  logic [FIX_W-1:0]         m_axis_tdata;
  logic                     cfg_valid_i   = 1'b0;
  logic                     cfg_ready_o;
  cfg_idx_t                 cfg_index_i   = '0;
  logic [FIX_W-1:0]         cfg_data_i    = '0;

  scalar_kalman_rssi_smoother #(
    .FRAC_BITS(FRAC_BITS),
    .GAIN_BITS(GAIN_BITS)
  ) u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Filter state and register copies
  logic [FIX_W-1:0]        q_reg = Q_DEFAULT;
  logic [FIX_W-1:0]        r_reg = R_DEFAULT;
  logic signed [FIX_W-1:0] est_fix;
  logic [FIX_W-1:0]        var_fix;
  bit                      primed;

  logic [FIX_W-1:0] smoothed_q[$];
  logic [FIX_W-1:0] want_est;
  int unsigned      error_count;
  int unsigned      result_count;
  int unsigned      sample_count;
  int unsigned      write_count;
  int unsigned      setting_count;
  bit               calm_in;
  bit               calm_out;
  bit               hold_output;

  function automatic longint clamp_s16(longint x);
    if (x > 32767) return 32767;
    if (x < -32768) return -32768;
    return x;
  endfunction

  function automatic void clear_filter();
    est_fix = '0;
    var_fix = VAR_RESET;
    primed  = 1'b0;
  endfunction

  function automatic void apply_register(cfg_idx_t idx, logic [FIX_W-1:0] val);
    case (idx)
      REG_PROCESS_NOISE: begin
        q_reg = val;
        clear_filter();
      end
      REG_MEASUREMENT_NOISE: begin
        r_reg = val;
        clear_filter();
      end
      default: ;
    endcase
  endfunction

  function automatic logic [FIX_W-1:0] kalman_advance(logic signed [RSSI_W-1:0] raw);
    longint sample, q_eff, r_eff, v, gain, diff, mag, step_sz, nv, half;
    half   = longint'(1) << (GAIN_BITS - 1);
    sample = clamp_s16(longint'(raw) * (longint'(1) << FRAC_BITS));
    q_eff  = (q_reg == '0) ? longint'(Q_DEFAULT) : longint'(q_reg);
    r_eff  = (r_reg == '0) ? longint'(R_DEFAULT) : longint'(r_reg);
    if (!primed) begin
      est_fix = sample[FIX_W-1:0];
      var_fix = r_eff[FIX_W-1:0];
      primed  = 1'b1;
    end else begin
      v = longint'(var_fix) + q_eff;
      if (v > 65535) v = 65535;
      gain    = (v << GAIN_BITS) / (v + r_eff);
      diff    = sample - longint'(est_fix);
      mag     = (diff < 0) ? -diff : diff;
      step_sz = (mag * gain + half) >>> GAIN_BITS;
      sample  = clamp_s16(longint'(est_fix) + ((diff < 0) ? -step_sz : step_sz));
      est_fix = sample[FIX_W-1:0];
      nv      = (v * ((longint'(1) << GAIN_BITS) - gain) + half) >>> GAIN_BITS;
      if (nv > 65535) nv = 65535;
      var_fix = nv[FIX_W-1:0];
    end
    return est_fix;
  endfunction

  function automatic logic [FIX_W-1:0] pick_noise();
    case ($urandom_range(5))
      0:       return '0;
      1:       return 16'h0001;
      2:       return 16'hFFFF;
      3:       return FIX_W'($urandom_range(2048, 16));
      default: return FIX_W'($urandom_range(65535));
    endcase
  endfunction

  // Offer one sample, hold until the transfer, then record the expected estimate
  task automatic send_sample(logic signed [RSSI_W-1:0] raw, logic typed,
                             logic [FIX_W-1:0] want_val);
    logic [FIX_W-1:0] pred;
    int unsigned      gap;
    gap = (!calm_in && $urandom_range(99) < 30) ? $urandom_range(6, 1) : 0;
    cfg_valid_i <= 1'b0;
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= raw;
    do @(posedge clk_i); while (!s_axis_tready);
    pred = kalman_advance(raw);
    smoothed_q.push_back(typed ? want_val : pred);
    sample_count++;
  endtask

  task automatic write_register(cfg_idx_t idx, logic [FIX_W-1:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    apply_register(idx, val);
    write_count++;
  endtask

  task automatic drain();
    s_axis_tvalid <= 1'b0;
    while (smoothed_q.size() != 0) @(posedge clk_i);
  endtask

  // Output side: random backpressure, one long hold-off on request
  initial begin
    forever begin
      @(posedge clk_i);
      if (hold_output) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        hold_output = 1'b0;
      end
      m_axis_tready <= calm_out || ($urandom_range(99) >= 30);
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      result_count++;
      if (smoothed_q.size() == 0) begin
        error_count++;
        $display("%0t: unexpected smoothed_rssi transfer, expected none, actual %h",
                 $time, m_axis_tdata);
      end else begin
        want_est = smoothed_q.pop_front();
        if (m_axis_tdata !== want_est) begin
          error_count++;
          $display("%0t: smoothed_rssi mismatch, expected %h, actual %h",
                   $time, want_est, m_axis_tdata);
        end
      end
    end
  end

  initial begin
    #(5_000_000);
    $display("DONE: errors detected");
    $finish;
  end

  initial begin
    stim_row_t   row;
    bit          last_was_sample;
    int unsigned n_items;
    int unsigned mode;
    int          lvl;
    int          s_val;

    clear_filter();
    last_was_sample = 1'b0;
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;

    for (int i = 0; i < N_DIRECTED; i++) begin
      row = DIRECTED_ROWS[i];
      if (row.kind == ROW_WRITE) begin
        if (last_was_sample) drain();
        write_register(row.idx, row.val);
        last_was_sample = 1'b0;
      end else begin
        send_sample(row.raw, row.typed, row.want);
        last_was_sample = 1'b1;
      end
    end
    drain();

    setting_count = 5;
    while (sample_count < SAMPLE_TARGET) begin
      setting_count++;
      calm_in  = (setting_count == 11);
      calm_out = (setting_count == 11);
      if (setting_count % 6 == 2) begin
        write_register($urandom_range(1) ? REG_SPARE_A : REG_SPARE_B,
                       FIX_W'($urandom_range(65535)));
      end else begin
        write_register(REG_PROCESS_NOISE, pick_noise());
        write_register(REG_MEASUREMENT_NOISE, pick_noise());
      end
      if (setting_count == 8) hold_output = 1'b1;

      n_items = $urandom_range(80, 15);
      mode    = $urandom_range(9);
      lvl     = -$urandom_range(100, 30);
      repeat (n_items) begin
        if (mode < 6) begin
          // drifting level with jitter, rare jumps
          if ($urandom_range(19) == 0) lvl = -$urandom_range(110, 20);
          s_val = lvl + $urandom_range(10) - 5;
        end else if (mode < 8) begin
          s_val = $urandom_range(255) - 128;
        end else begin
          s_val = $urandom_range(1) ? 127 : -128;
        end
        if (s_val > 127) s_val = 127;
        if (s_val < -128) s_val = -128;
        send_sample(s_val[RSSI_W-1:0], 1'b0, '0);
      end
      drain();
    end

    calm_in  = 1'b0;
    calm_out = 1'b0;
    repeat (SETTLE_CYCLES) @(posedge clk_i);

    $display("Run covered %0d samples over %0d filter settings and %0d register writes,",
             sample_count, setting_count, write_count);
    $display("with %0d estimates compared under random stalls and one long output hold.",
             result_count);
    if (error_count == 0 && smoothed_q.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
